@@ rtl/pfed_pkg.sv @@
// ----------------------------------------------------------------------------
// pfed_pkg: shared definitions for the fill end detector
// Field widths, reset values, register indexes and the controller states.
// ----------------------------------------------------------------------------
package pfed_pkg;

  localparam int TimeW    = 32;
  localparam int PresW    = 16;
  localparam int CntW     = 5;
  localparam int ClassW   = 3;
  localparam int StepW    = 15;
  localparam int ThrW     = 16;
  localparam int NumThr   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam int ConfirmCountDefault = 3;

  localparam logic signed [PresW-1:0] InitLimitReset = 16'sd200;
  localparam logic [TimeW-1:0]        DecayIntReset  = 32'd1000;
  localparam logic [StepW-1:0]        DecayStepReset = 15'd10;
  localparam logic signed [PresW-1:0] LimitFloor     = 16'sh8000;

  // Mode 0 scales the filling time by 512; mode 1 scales the stable time
  // by 100, built as 64 + 32 + 4.
  localparam int RatioShift = 9;
  localparam int MulShiftA  = 6;
  localparam int MulShiftB  = 5;
  localparam int MulShiftC  = 2;

  localparam logic FuncStart   = 1'b0;
  localparam logic ModeRatio   = 1'b0;
  localparam logic ModeStable  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INIT_LIMIT,
    REG_DECAY_INTERVAL,
    REG_DECAY_STEP,
    REG_CLASS_MODE,
    REG_THRESHOLD_A,
    REG_THRESHOLD_B,
    REG_THRESHOLD_C,
    REG_THRESHOLD_D
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLASS,
    ST_OUT
  } pfed_state_t;

endpackage

@@ rtl/pfed_in_if.sv @@
// ----------------------------------------------------------------------------
// pfed_in_if: sample channel
// Valid/ready channel carrying one pressure item.
// ----------------------------------------------------------------------------
interface pfed_in_if import pfed_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [PresW-1:0] pressure;
  logic [TimeW-1:0]        now_time;

  modport source (output valid, func, pressure, now_time, input ready);
  modport sink   (input valid, func, pressure, now_time, output ready);
endinterface

@@ rtl/pfed_out_if.sv @@
// ----------------------------------------------------------------------------
// pfed_out_if: result channel
// Valid/ready channel carrying one detector result item.
// ----------------------------------------------------------------------------
interface pfed_out_if import pfed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              fill_done;
  logic [ClassW-1:0] fill_class;
  logic [TimeW-1:0]  fill_duration;
  logic [TimeW-1:0]  detach_moment;
  logic [TimeW-1:0]  steady_duration;
  logic              peak_found;

  modport source (output valid, fill_done, fill_class, fill_duration, detach_moment,
                  steady_duration, peak_found, input ready);
  modport sink   (input valid, fill_done, fill_class, fill_duration, detach_moment,
                  steady_duration, peak_found, output ready);
endinterface

@@ rtl/pfed_div.sv @@
// ----------------------------------------------------------------------------
// pfed_div: bit-serial unsigned divider
// Restoring division producing one quotient bit per cycle; a zero divisor
// yields all ones.
// ----------------------------------------------------------------------------
module pfed_div
  import pfed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TimeW-1:0] num,
  input  logic [TimeW-1:0] den,
  output logic             done,
  output logic [TimeW-1:0] quot
);

  localparam int StepCntW = $clog2(TimeW);

  logic                busy_r;
  logic                done_r;
  logic [StepCntW-1:0] step_r;
  logic [TimeW-1:0]    rem_r;
  logic [TimeW-1:0]    quo_r;
  logic [TimeW-1:0]    den_r;
  logic [TimeW:0]      shifted;
  logic [TimeW:0]      diff;
  logic                fits;

  assign shifted = {rem_r, quo_r[TimeW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = ~diff[TimeW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= StepCntW'(TimeW - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - StepCntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[TimeW-1:0] : shifted[TimeW-1:0];
      quo_r <= {quo_r[TimeW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ rtl/pressure_fill_end_detector.sv @@
// ----------------------------------------------------------------------------
// pressure_fill_end_detector: end-of-filling detector
// Tracks pressure deltas of a run, finds the first peak, confirms the end of
// filling and classifies the run against a threshold table.
// ----------------------------------------------------------------------------
// Items enter on in_ch (valid/ready). func 0 opens a new run at the given
// pressure and time; func 1 processes a pressure sample. Every item gives
// exactly one result item on out_ch.
// A sample item passes ST_CALC, ST_UPDATE and ST_OUT to the result register,
// a start item ST_CALC and ST_OUT. A sample that confirms the end of filling
// runs the bit-serial divider, which produces one quotient bit per cycle; in
// mode 1 ST_MUL_A and ST_MUL_B first form the numerator.
// Synchronous reset loads the register defaults and the initial run state.
// The block works on one item at a time: in_ch.ready is high while the
// controller is idle. The result register lets a new item be accepted while
// the previous result still waits; if the receiver stalls, the finished
// item waits in the controller until the result register is free.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pressure_fill_end_detector
  import pfed_pkg::*;
#(
  parameter int CONFIRM_COUNT = ConfirmCountDefault
)
(
  input  logic                clk,
  input  logic                rst_n,
  pfed_in_if.sink             in_ch,
  pfed_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic [CntW-1:0] CntConfirm = CntW'(CONFIRM_COUNT);

  // Configuration registers.
  logic signed [PresW-1:0] init_limit_r;
  logic [TimeW-1:0]        decay_int_r;
  logic [StepW-1:0]        decay_step_r;
  logic                    class_mode_r;
  logic [ThrW-1:0]         thr_r [NumThr];

  // Run state.
  pfed_state_t             state_r, state_nxt;
  logic                    peak_seen_r;
  logic signed [PresW-1:0] limit_r;
  logic signed [PresW-1:0] prev_delta_r;
  logic [CntW-1:0]         cnt_r;
  logic signed [PresW-1:0] prev_p_r;
  logic [TimeW-1:0]        start_r;
  logic [TimeW-1:0]        filling_r;
  logic [TimeW-1:0]        detach_r;
  logic [TimeW-1:0]        stable_r;
  logic [TimeW-1:0]        last_decay_r;
  logic                    hit_r;
  logic [ClassW-1:0]       class_r;

  // Item and working registers.
  logic                    func_r;
  logic signed [PresW-1:0] p_r;
  logic [TimeW-1:0]        now_r;
  logic [TimeW-1:0]        elapsed_r;
  logic [TimeW-1:0]        age_r;
  logic signed [PresW-1:0] delta_r;
  logic [TimeW-1:0]        num_r;
  logic [TimeW-1:0]        den_r;

  // Result register.
  logic                    out_valid_r;
  logic                    out_done_r;
  logic [ClassW-1:0]       out_class_r;
  logic [TimeW-1:0]        out_filling_r;
  logic [TimeW-1:0]        out_detach_r;
  logic [TimeW-1:0]        out_stable_r;
  logic                    out_peak_r;

  // Controller outputs.
  logic in_ready;
  logic div_start;
  logic out_load;

  // Sample update logic.
  logic signed [PresW-1:0] delta_eff;
  logic signed [PresW-1:0] cur_eff;
  logic [CntW-1:0]         cnt_inc;
  logic [CntW-1:0]         cnt_upd;
  logic                    hit;
  logic [TimeW-1:0]        stable_upd;
  logic [TimeW-1:0]        filling_upd;
  logic                    peak_now;
  logic [TimeW-1:0]        detach_upd;
  logic                    decay;
  logic signed [PresW:0]   lim_diff;
  logic signed [PresW-1:0] lim_new;

  // Classification logic.
  logic                    div_done;
  logic [TimeW-1:0]        quot;
  logic [TimeW-1:0]        metric;
  logic [ClassW-1:0]       cls_calc;
  logic                    cls_run;

  pfed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_limit_r <= InitLimitReset;
      decay_int_r  <= DecayIntReset;
      decay_step_r <= DecayStepReset;
      class_mode_r <= ModeRatio;
      for (int i = 0; i < NumThr; i++) begin
        thr_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INIT_LIMIT:     init_limit_r <= cfg_data[PresW-1:0];
        REG_DECAY_INTERVAL: decay_int_r  <= cfg_data[TimeW-1:0];
        REG_DECAY_STEP:     decay_step_r <= cfg_data[StepW-1:0];
        REG_CLASS_MODE:     class_mode_r <= cfg_data[0];
        REG_THRESHOLD_A:    thr_r[0]     <= cfg_data[ThrW-1:0];
        REG_THRESHOLD_B:    thr_r[1]     <= cfg_data[ThrW-1:0];
        REG_THRESHOLD_C:    thr_r[2]     <= cfg_data[ThrW-1:0];
        REG_THRESHOLD_D:    thr_r[3]     <= cfg_data[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_CALC;
      ST_CALC:     state_nxt = (func_r == FuncStart) ? ST_OUT : ST_UPDATE;
      ST_UPDATE: begin
        if (!hit) begin
          state_nxt = ST_OUT;
        end else if (class_mode_r == ModeStable) begin
          state_nxt = ST_MUL_A;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_MUL_A:    state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = ST_CLASS;
      ST_CLASS:    state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_DIV_GO);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    cnt_inc     = cnt_r + CntW'(1);
    delta_eff   = delta_r;
    cur_eff     = p_r;
    cnt_upd     = cnt_r;
    hit         = 1'b0;
    stable_upd  = stable_r;
    filling_upd = filling_r;
    if (peak_seen_r) begin
      if (delta_r > limit_r) begin
        cnt_upd = cnt_inc;
        if (cnt_inc == CntConfirm) begin
          hit         = 1'b1;
          filling_upd = elapsed_r;
        end else begin
          delta_eff = prev_delta_r;
          cur_eff   = prev_p_r;
        end
      end else begin
        cnt_upd    = '0;
        stable_upd = elapsed_r - detach_r;
      end
    end
    peak_now   = (delta_eff < prev_delta_r);
    detach_upd = (peak_now && !peak_seen_r) ? elapsed_r : detach_r;
    decay      = (age_r > decay_int_r);
    lim_diff   = {limit_r[PresW-1], limit_r} - $signed({2'b00, decay_step_r});
    lim_new    = (lim_diff[PresW] != lim_diff[PresW-1]) ? LimitFloor : lim_diff[PresW-1:0];
  end

  always_comb begin
    metric   = (class_mode_r == ModeStable) ? {{(TimeW-ThrW){1'b0}}, quot[ThrW-1:0]} : quot;
    cls_calc = '0;
    cls_run  = 1'b1;
    for (int i = 0; i < NumThr; i++) begin
      if (cls_run && (thr_r[i] != '0) && (metric >= {{(TimeW-ThrW){1'b0}}, thr_r[i]})) begin
        cls_calc = cls_calc + ClassW'(1);
      end else begin
        cls_run = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      peak_seen_r  <= 1'b0;
      limit_r      <= InitLimitReset;
      prev_delta_r <= '0;
      cnt_r        <= '0;
      prev_p_r     <= '0;
      start_r      <= '0;
      filling_r    <= '0;
      detach_r     <= '0;
      stable_r     <= '0;
      last_decay_r <= '0;
      hit_r        <= 1'b0;
      class_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC && func_r == FuncStart) begin
        peak_seen_r  <= 1'b0;
        limit_r      <= init_limit_r;
        prev_delta_r <= '0;
        cnt_r        <= '0;
        prev_p_r     <= p_r;
        start_r      <= now_r;
        filling_r    <= '0;
        detach_r     <= '0;
        stable_r     <= '0;
        last_decay_r <= now_r;
        hit_r        <= 1'b0;
        class_r      <= '0;
      end
      if (state_r == ST_UPDATE) begin
        cnt_r       <= cnt_upd;
        stable_r    <= stable_upd;
        filling_r   <= filling_upd;
        detach_r    <= detach_upd;
        peak_seen_r <= peak_seen_r | peak_now;
        prev_p_r    <= cur_eff;
        if (!delta_eff[PresW-1]) begin
          prev_delta_r <= delta_eff;
        end
        if (decay) begin
          limit_r      <= lim_new;
          last_decay_r <= now_r;
        end
        hit_r   <= hit;
        class_r <= '0;
      end
      if (state_r == ST_CLASS) begin
        class_r <= cls_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      func_r <= in_ch.func;
      p_r    <= in_ch.pressure;
      now_r  <= in_ch.now_time;
    end
    if (state_r == ST_CALC) begin
      elapsed_r <= now_r - start_r;
      age_r     <= now_r - last_decay_r;
      delta_r   <= p_r - prev_p_r;
    end
    if (state_r == ST_UPDATE) begin
      num_r <= {elapsed_r[TimeW-1-RatioShift:0], {RatioShift{1'b0}}};
      den_r <= (class_mode_r == ModeStable) ? elapsed_r
                                            : {{(TimeW-PresW){cur_eff[PresW-1]}}, cur_eff};
    end
    if (state_r == ST_MUL_A) begin
      num_r <= (stable_r << MulShiftA) + (stable_r << MulShiftB);
    end
    if (state_r == ST_MUL_B) begin
      num_r <= num_r + (stable_r << MulShiftC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_done_r    <= hit_r;
      out_class_r   <= class_r;
      out_filling_r <= filling_r;
      out_detach_r  <= detach_r;
      out_stable_r  <= stable_r;
      out_peak_r    <= peak_seen_r;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.fill_done       = out_done_r;
  assign out_ch.fill_class      = out_class_r;
  assign out_ch.fill_duration   = out_filling_r;
  assign out_ch.detach_moment   = out_detach_r;
  assign out_ch.steady_duration = out_stable_r;
  assign out_ch.peak_found      = out_peak_r;

  // An end of filling can only be reported after a peak.
  a_done_after_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.fill_done |-> out_ch.peak_found)
    else $error("end of filling reported without a peak");

  // A class is given only with an end of filling.
  a_class_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.fill_done |-> out_ch.fill_class == '0)
    else $error("class reported without end of filling");

  // The confirmation counter runs only after the peak.
  a_count_after_peak: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> peak_seen_r)
    else $error("confirmation counter active before the peak");

  // The divider finishes only while the controller waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule
